// ===== hdl/box_iou_gt_matcher_macros.svh =====
// Assertion shorthands used by the matcher top level.
`ifndef BOX_IOU_GT_MATCHER_MACROS_SVH
`define BOX_IOU_GT_MATCHER_MACROS_SVH

// same-cycle implication
`define BIGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BIGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bigm_pkg.sv =====
package bigm_pkg;

	localparam int MAX_GT_DEF = 64;
	localparam int ONE_PIXEL  = 16;
	localparam int FRAC_BITS  = 16;

	// opcodes of an input word
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register indexes
	localparam logic [7:0] REG_GT_COUNT = 8'd0;
	localparam logic [7:0] REG_FG_THR   = 8'd1;
	localparam logic [7:0] REG_BG_HIGH  = 8'd2;
	localparam logic [7:0] REG_BG_LOW   = 8'd3;

	localparam logic [16:0] FG_THR_RST  = 17'd32768;
	localparam logic [16:0] BG_HIGH_RST = 17'd32768;
	localparam logic [16:0] BG_LOW_RST  = 17'd0;

	typedef struct packed {
		logic wr;        // store a ground-truth entry
		logic ld_prop;   // capture proposal box
		logic clr_best;  // reset running best
		logic rd;        // read box table
		logic mul_prop;  // proposal area
		logic mul_inter; // intersection area
		logic mul_gt;    // ground-truth area
		logic uni;       // union
		logic dinit;     // first quotient bit
		logic dstep;     // one fraction bit
		logic upd;       // compare against best
		logic lbl_rd;    // read label of best
		logic out_load;  // fill output register
		logic no_gt;     // empty table result
	} cmd_t;

	typedef struct packed {
		logic ovl;       // current pair overlaps
		logic out_busy;  // output word not yet taken
	} sts_t;

endpackage

// ===== hdl/bigm_dp.sv =====
module bigm_dp import bigm_pkg::*; #(
	parameter int MAX_GT = MAX_GT_DEF,
	parameter int IW     = (MAX_GT > 1) ? $clog2(MAX_GT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [IW-1:0] ent_idx,
	output sts_t          sts,
	input  logic [5:0]    entry_index,
	input  logic [15:0]   box_x1,
	input  logic [15:0]   box_y1,
	input  logic [15:0]   box_x2,
	input  logic [15:0]   box_y2,
	input  logic [7:0]    class_label,
	input  logic [16:0]   fg_threshold,
	input  logic [16:0]   bg_threshold_high,
	input  logic [16:0]   bg_threshold_low,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [5:0]    best_index,
	output logic [16:0]   best_overlap,
	output logic [7:0]    best_label,
	output logic          is_foreground,
	output logic          is_background
);

	logic [63:0] box_mem [MAX_GT];
	logic [7:0]  lbl_mem [MAX_GT];

	logic [63:0]   rd_box_q;
	logic [7:0]    lbl_q;
	logic [15:0]   px1_q, py1_q, px2_q, py2_q;
	logic [16:0]   iw_q, ih_q, gw_q, gh_q;
	logic          ovl_q;
	logic [33:0]   area_a_q, area_b_q, inter_q;
	logic [34:0]   uni_q, rem_q;
	logic [16:0]   quo_q, best_q;
	logic [IW-1:0] best_idx_q;
	logic          out_valid_q;

	logic [15:0] gx1, gy1, gx2, gy2, mx1, my1, mx2, my2;
	logic [17:0] iw18, ih18, gw18, gh18, pw18, ph18;
	logic [16:0] mul_a, mul_b, upd_v;
	logic [33:0] prod;
	logic [35:0] r2;
	logic        ge, ge0, wr_ok;
	logic [IW-1:0] wr_addr;

	assign wr_ok   = 32'(entry_index) < MAX_GT;
	assign wr_addr = IW'(entry_index);

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			box_mem[wr_addr] <= {box_y2, box_x2, box_y1, box_x1};
			lbl_mem[wr_addr] <= class_label;
		end
		if (cmd.rd)
			rd_box_q <= box_mem[ent_idx];
		if (cmd.lbl_rd)
			lbl_q <= lbl_mem[best_idx_q];
	end

	assign gx1 = rd_box_q[15:0];
	assign gy1 = rd_box_q[31:16];
	assign gx2 = rd_box_q[47:32];
	assign gy2 = rd_box_q[63:48];
	assign mx1 = (px1_q > gx1) ? px1_q : gx1;
	assign my1 = (py1_q > gy1) ? py1_q : gy1;
	assign mx2 = (px2_q < gx2) ? px2_q : gx2;
	assign my2 = (py2_q < gy2) ? py2_q : gy2;
	// 18-bit two's complement: sign bit flags an empty extent
	assign iw18 = {2'b0, mx2} - {2'b0, mx1} + 18'(ONE_PIXEL);
	assign ih18 = {2'b0, my2} - {2'b0, my1} + 18'(ONE_PIXEL);
	assign gw18 = {2'b0, gx2} - {2'b0, gx1} + 18'(ONE_PIXEL);
	assign gh18 = {2'b0, gy2} - {2'b0, gy1} + 18'(ONE_PIXEL);
	assign pw18 = {2'b0, px2_q} - {2'b0, px1_q} + 18'(ONE_PIXEL);
	assign ph18 = {2'b0, py2_q} - {2'b0, py1_q} + 18'(ONE_PIXEL);

	// single shared multiplier
	always_comb begin
		mul_a = pw18[16:0];
		mul_b = ph18[16:0];
		if (cmd.mul_inter) begin
			mul_a = iw_q;
			mul_b = ih_q;
		end else if (cmd.mul_gt) begin
			mul_a = gw_q;
			mul_b = gh_q;
		end
	end
	assign prod = mul_a * mul_b;

	assign ge0   = {1'b0, inter_q} >= uni_q;
	assign r2    = {rem_q, 1'b0};
	assign ge    = r2 >= {1'b0, uni_q};
	assign upd_v = ovl_q ? quo_q : 17'd0;

	always_ff @(posedge clk) begin
		if (cmd.ld_prop) begin
			px1_q <= box_x1;
			py1_q <= box_y1;
			px2_q <= box_x2;
			py2_q <= box_y2;
		end
		// geometry is registered the cycle after the table read
		iw_q  <= iw18[16:0];
		ih_q  <= ih18[16:0];
		gw_q  <= gw18[16:0];
		gh_q  <= gh18[16:0];
		if (cmd.rd)
			ovl_q <= 1'b0;
		else
			ovl_q <= !iw18[17] && (iw18 != 18'd0) && !ih18[17] && (ih18 != 18'd0);
		if (cmd.mul_prop)
			area_a_q <= prod;
		if (cmd.mul_inter)
			inter_q <= prod;
		if (cmd.mul_gt)
			area_b_q <= prod;
		if (cmd.uni)
			uni_q <= 35'(area_a_q) + 35'(area_b_q) - 35'(inter_q);
		if (cmd.dinit) begin
			rem_q <= ge0 ? ({1'b0, inter_q} - uni_q) : {1'b0, inter_q};
			quo_q <= {16'd0, ge0};
		end else if (cmd.dstep) begin
			rem_q <= ge ? 35'(r2 - {1'b0, uni_q}) : r2[34:0];
			quo_q <= {quo_q[15:0], ge};
		end
		if (cmd.clr_best) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (cmd.upd && (upd_v > best_q)) begin
			best_q     <= upd_v;
			best_idx_q <= ent_idx;
		end
		if (cmd.out_load) begin
			best_index    <= 6'(best_idx_q);
			best_overlap  <= best_q;
			best_label    <= cmd.no_gt ? 8'd0 : lbl_q;
			is_foreground <= best_q >= fg_threshold;
			is_background <= (best_q >= bg_threshold_low) && (best_q < bg_threshold_high);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.ovl      = ovl_q;
	assign sts.out_busy = out_valid_q;

endmodule

// ===== hdl/bigm_ctrl.sv =====
module bigm_ctrl import bigm_pkg::*; #(
	parameter int MAX_GT = MAX_GT_DEF,
	parameter int IW     = (MAX_GT > 1) ? $clog2(MAX_GT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [6:0]    gt_count,
	input  logic          out_ready,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic [IW-1:0] ent_idx
);

	localparam int CW = $clog2(MAX_GT + 1);
	localparam int NW = (CW > 7) ? CW : 7;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PAREA = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_GEOM  = 4'd3;
	localparam logic [3:0] S_MINT  = 4'd4;
	localparam logic [3:0] S_MGT   = 4'd5;
	localparam logic [3:0] S_UNI   = 4'd6;
	localparam logic [3:0] S_DINIT = 4'd7;
	localparam logic [3:0] S_DSTEP = 4'd8;
	localparam logic [3:0] S_UPD   = 4'd9;
	localparam logic [3:0] S_LBL   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [3:0]    dcnt_q, dcnt_d;
	logic [NW-1:0] gtc, n_eff;
	logic          no_gt, last;

	assign gtc   = NW'(gt_count);
	assign n_eff = (gtc > NW'(MAX_GT)) ? NW'(MAX_GT) : gtc;
	assign no_gt = n_eff == '0;
	assign last  = (NW'(idx_q) + NW'(1)) == n_eff;

	assign in_ready = state_q == S_IDLE;
	assign ent_idx  = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		dcnt_d  = dcnt_q;
		cmd     = '0;
		cmd.no_gt = no_gt;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_LOAD) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.ld_prop  = 1'b1;
						cmd.clr_best = 1'b1;
						idx_d        = '0;
						state_d      = S_PAREA;
					end
				end
			end
			S_PAREA: begin
				cmd.mul_prop = 1'b1;
				state_d      = no_gt ? S_FIN : S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_GEOM;
			end
			S_GEOM: state_d = S_MINT;
			S_MINT: begin
				if (sts.ovl) begin
					cmd.mul_inter = 1'b1;
					state_d       = S_MGT;
				end else begin
					state_d = S_UPD;
				end
			end
			S_MGT: begin
				cmd.mul_gt = 1'b1;
				state_d    = S_UNI;
			end
			S_UNI: begin
				cmd.uni = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.dinit = 1'b1;
				dcnt_d    = '0;
				state_d   = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.dstep = 1'b1;
				dcnt_d    = dcnt_q + 4'd1;
				if (dcnt_q == 4'(FRAC_BITS - 1))
					state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				if (last) begin
					state_d = S_LBL;
				end else begin
					idx_d   = idx_q + IW'(1);
					state_d = S_RD;
				end
			end
			S_LBL: begin
				cmd.lbl_rd = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_busy || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			dcnt_q  <= dcnt_d;
		end
	end

endmodule

// ===== hdl/box_iou_gt_matcher.sv =====
// Ground-truth matcher: load words (op 0) store a box and class label in slot
// entry_index of a MAX_GT-entry table and give no result. Query words
// (op 1) compare the proposal with the first gt_count slots by inclusive-extent
// IoU in Q1.16 and return the best slot (lowest on ties), its IoU and label, and
// the foreground/background flags. Slots must be loaded before a query reads them.
// A query steps through accept and proposal area on the shared 17x17 multiplier,
// then per slot a table read, geometry and overlap check; an overlapping slot adds
// its intersection and ground-truth areas, the union and a restoring divider
// producing one quotient bit per cycle. A label read (skipped with an empty table)
// and the output load end the query. One query is in flight at a time; the
// output register lets the next word be accepted while a result waits.
// Registers (cfg_index): 0 gt_count, 1 fg_threshold, 2 bg_threshold_high,
// 3 bg_threshold_low; write only while idle. cfg_ready is always high.
`include "box_iou_gt_matcher_macros.svh"

module box_iou_gt_matcher import bigm_pkg::*; #(
	parameter int MAX_GT = MAX_GT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [5:0]  entry_index,
	input  logic [15:0] box_x1,
	input  logic [15:0] box_y1,
	input  logic [15:0] box_x2,
	input  logic [15:0] box_y2,
	input  logic [7:0]  class_label,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  best_index,
	output logic [16:0] best_overlap,
	output logic [7:0]  best_label,
	output logic        is_foreground,
	output logic        is_background
);

	localparam int IW = (MAX_GT > 1) ? $clog2(MAX_GT) : 1;

	logic [6:0]    gt_count_q;
	logic [16:0]   fg_thr_q, bg_high_q, bg_low_q;
	cmd_t          cmd;
	sts_t          sts;
	logic [IW-1:0] ent_idx;
	logic          in_acc;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_count_q <= '0;
			fg_thr_q   <= FG_THR_RST;
			bg_high_q  <= BG_HIGH_RST;
			bg_low_q   <= BG_LOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GT_COUNT: gt_count_q <= cfg_data[6:0];
				REG_FG_THR:   fg_thr_q   <= cfg_data[16:0];
				REG_BG_HIGH:  bg_high_q  <= cfg_data[16:0];
				REG_BG_LOW:   bg_low_q   <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// sequencer
	bigm_ctrl #(.MAX_GT(MAX_GT), .IW(IW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.gt_count  (gt_count_q),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.ent_idx   (ent_idx)
	);

	// table, IoU arithmetic and output register
	bigm_dp #(.MAX_GT(MAX_GT), .IW(IW)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.ent_idx           (ent_idx),
		.sts               (sts),
		.entry_index       (entry_index),
		.box_x1            (box_x1),
		.box_y1            (box_y1),
		.box_x2            (box_x2),
		.box_y2            (box_y2),
		.class_label       (class_label),
		.fg_threshold      (fg_thr_q),
		.bg_threshold_high (bg_high_q),
		.bg_threshold_low  (bg_low_q),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.best_index        (best_index),
		.best_overlap      (best_overlap),
		.best_label        (best_label),
		.is_foreground     (is_foreground),
		.is_background     (is_background)
	);

	// a query word keeps the block busy the following cycle
	`BIGM_ASSERT_NEXT(a_query_busy, clk, arst_n, in_acc && (op == OP_QUERY), !in_ready, "query did not start")
	// a load word leaves the block ready again the next cycle
	`BIGM_ASSERT_NEXT(a_load_one, clk, arst_n, in_acc && (op == OP_LOAD), in_ready, "load stalled")
	// IoU never exceeds one
	`BIGM_ASSERT_NOW(a_iou_range, clk, arst_n, out_valid, best_overlap <= 17'h10000, "IoU above one")

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import bigm_pkg::*;

	// one ground-truth or proposal word as the sender presents it
	typedef struct {
		logic        op;
		logic [5:0]  slot;
		logic [15:0] x1, y1, x2, y2;
		logic [7:0]  lbl;
	} box_word_t;

	// one match result
	typedef struct {
		logic [5:0]  idx;
		logic [16:0] ovl;
		logic [7:0]  lbl;
		logic        fg, bg;
	} match_t;

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid, in_ready;
	logic        op;
	logic [5:0]  entry_index;
	logic [15:0] box_x1, box_y1, box_x2, box_y2;
	logic [7:0]  class_label;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  best_index;
	logic [16:0] best_overlap;
	logic [7:0]  best_label;
	logic        is_foreground, is_background;

	box_iou_gt_matcher DUT (.*);

	// shadow of the block's table and registers
	logic [15:0] gt_x1 [64], gt_y1 [64], gt_x2 [64], gt_y2 [64];
	logic [7:0]  gt_lbl [64];
	int unsigned n_gt;
	logic [16:0] fg_thr, bg_hi, bg_lo;

	match_t      pending_matches [$];
	int          mismatches = 0, matches_seen = 0, idle_cycles = 0;
	int          words_sent;
	bit          hold_off;       // long receiver stall in progress
	bit          burst_mode;     // sender gaps enabled

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// IoU in Q1.16, inclusive extents, floor
	function automatic logic [16:0] iou_q16(box_word_t a, int s);
		longint iw, ih, aa, ab, inter, uni;
		iw = ((a.x2 < gt_x2[s]) ? a.x2 : gt_x2[s]) - ((a.x1 > gt_x1[s]) ? a.x1 : gt_x1[s])
			+ ONE_PIXEL;
		ih = ((a.y2 < gt_y2[s]) ? a.y2 : gt_y2[s]) - ((a.y1 > gt_y1[s]) ? a.y1 : gt_y1[s])
			+ ONE_PIXEL;
		if (iw <= 0 || ih <= 0) return 0;
		aa = (longint'(a.x2) - a.x1 + ONE_PIXEL) * (longint'(a.y2) - a.y1 + ONE_PIXEL);
		ab = (longint'(gt_x2[s]) - gt_x1[s] + ONE_PIXEL) *
			(longint'(gt_y2[s]) - gt_y1[s] + ONE_PIXEL);
		inter = iw * ih;
		uni = aa + ab - inter;
		if (uni == 0) return 0;
		return 17'((inter * 65536) / uni);
	endfunction

	// updates the table on a load, predicts the match on a query
	task automatic predict_word(box_word_t w);
		match_t m;
		logic [16:0] v;
		int n;
		if (w.op == OP_LOAD) begin
			gt_x1[w.slot] = w.x1; gt_y1[w.slot] = w.y1;
			gt_x2[w.slot] = w.x2; gt_y2[w.slot] = w.y2;
			gt_lbl[w.slot] = w.lbl;
			return;
		end
		n = (n_gt > 64) ? 64 : n_gt;
		m.idx = 0; m.ovl = 0; m.lbl = 0;
		if (n > 0) begin
			m.ovl = iou_q16(w, 0);
			for (int j = 1; j < n; j++) begin
				v = iou_q16(w, j);
				if (v > m.ovl) begin
					m.ovl = v;
					m.idx = 6'(j);
				end
			end
			m.lbl = gt_lbl[m.idx];
		end
		m.fg = m.ovl >= fg_thr;
		m.bg = (m.ovl >= bg_lo) && (m.ovl < bg_hi);
		pending_matches = {pending_matches, m};
	endtask

	// sends one word, holding valid until accepted; valid stays up for a
	// following word and drops only in a gap or when the sender goes idle
	task automatic send_word(box_word_t w);
		if (burst_mode && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		op <= w.op; entry_index <= w.slot;
		box_x1 <= w.x1; box_y1 <= w.y1; box_x2 <= w.x2; box_y2 <= w.y2;
		class_label <= w.lbl;
		do @(posedge clk); while (!in_ready);
		predict_word(w);
		words_sent++;
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_GT_COUNT: n_gt = 32'(val[6:0]);
			REG_FG_THR:   fg_thr = val[16:0];
			REG_BG_HIGH:  bg_hi = val[16:0];
			REG_BG_LOW:   bg_lo = val[16:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain results, then let an in-flight load settle
	task automatic wait_idle();
		in_valid <= 0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_thresholds(logic [16:0] f, logic [16:0] h, logic [16:0] l);
		write_reg(REG_FG_THR, 32'(f));
		write_reg(REG_BG_HIGH, 32'(h));
		write_reg(REG_BG_LOW, 32'(l));
	endtask

	function automatic box_word_t mk_box(logic o, logic [5:0] s, logic [15:0] a, b, c, d,
		logic [7:0] l);
		box_word_t w;
		w.op = o; w.slot = s; w.x1 = a; w.y1 = b; w.x2 = c; w.y2 = d; w.lbl = l;
		return w;
	endfunction

	// box near a given ground-truth slot so IoU lands anywhere in range
	function automatic box_word_t jitter_query(int s);
		box_word_t w;
		w = mk_box(OP_QUERY, 6'($urandom), 16'(gt_x1[s] + $urandom_range(0, 200) - 100),
			16'(gt_y1[s] + $urandom_range(0, 200) - 100),
			16'(gt_x2[s] + $urandom_range(0, 200) - 100),
			16'(gt_y2[s] + $urandom_range(0, 200) - 100), 8'($urandom));
		return w;
	endfunction

	function automatic box_word_t rand_gt(logic [5:0] s);
		logic [15:0] x, y;
		x = 16'($urandom_range(0, 3000)); y = 16'($urandom_range(0, 3000));
		return mk_box(OP_LOAD, s, x, y, 16'(x + $urandom_range(0, 800)),
			16'(y + $urandom_range(0, 800)), 8'($urandom));
	endfunction

	// directed corners: empty table, full coordinates, degenerate, identical, ties
	task automatic test_directed();
		write_reg(REG_GT_COUNT, 0);
		send_word(mk_box(OP_QUERY, 6'h3f, 0, 0, 16'hffff, 16'hffff, 8'hff));
		send_word(mk_box(OP_LOAD, 0, 0, 0, 16'hffff, 16'hffff, 8'hff));
		send_word(mk_box(OP_LOAD, 1, 100, 100, 200, 200, 8'h00));
		send_word(mk_box(OP_LOAD, 2, 100, 100, 200, 200, 8'h5a)); // tie with slot 1
		send_word(mk_box(OP_LOAD, 63, 16'hfff0, 16'hfff0, 16'hffff, 16'hffff, 8'ha5));
		for (int s = 3; s < 63; s++) send_word(rand_gt(6'(s)));
		wait_idle();
		write_reg(REG_GT_COUNT, 3);
		send_word(mk_box(OP_QUERY, 0, 100, 100, 200, 200, 0));   // exact, tie
		send_word(mk_box(OP_QUERY, 0, 0, 0, 16'hffff, 16'hffff, 0));
		send_word(mk_box(OP_QUERY, 0, 200, 100, 100, 200, 0));   // degenerate x
		send_word(mk_box(OP_QUERY, 0, 100, 200, 200, 100, 0));   // degenerate y
		send_word(mk_box(OP_QUERY, 0, 0, 0, 0, 0, 0));
		wait_idle();
		write_reg(REG_GT_COUNT, 127);  // clamps to full table
		send_word(mk_box(OP_QUERY, 6'h2a, 16'hfff0, 16'hfff0, 16'hffff, 16'hffff, 8'h11));
		send_word(mk_box(OP_QUERY, 0, 216, 100, 300, 200, 0));   // just touching edge
		wait_idle();
		write_reg(REG_GT_COUNT, 64);
		write_reg(8'd9, 32'hffff_ffff); // unknown register
		set_thresholds(17'h1ffff, 0, 17'h1ffff);
		send_word(mk_box(OP_QUERY, 0, 100, 100, 200, 200, 0));
		wait_idle();
		set_thresholds(0, 17'h1ffff, 0);
		send_word(mk_box(OP_QUERY, 0, 100, 100, 200, 200, 0));
		send_word(mk_box(OP_QUERY, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0));
		wait_idle();
		set_thresholds(65536, 65536, 65536);
		send_word(mk_box(OP_QUERY, 0, 100, 100, 200, 200, 0));
		wait_idle();
	endtask

	// random phases: reload slots, queries mostly near stored boxes
	task automatic test_random();
		box_word_t w;
		int s;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_GT_COUNT, (ph == 5) ? 64 : $urandom_range(1, 10));
			set_thresholds(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
				17'($urandom_range(0, 30000)));
			for (int i = 0; i < 60; i++) begin
				s = $urandom_range(0, (n_gt > 64 ? 64 : n_gt) - 1);
				case ($urandom_range(0, 9))
					0, 1: w = rand_gt(6'(s));
					2: w = mk_box(OP_QUERY, 6'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 8'($urandom));
					default: w = jitter_query(s);
				endcase
				send_word(w);
			end
			wait_idle();
		end
	endtask

	// receiver holds off while the sender keeps pushing queries
	task automatic test_backpressure();
		write_reg(REG_GT_COUNT, 4);
		hold_off = 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 6; i++) send_word(jitter_query(i % 4));
		join
		wait_idle();
	endtask

	// receiver: own stall pattern, checks each accepted result
	always @(posedge clk) begin
		match_t m;
		if (arst_n && out_valid && out_ready) begin
			matches_seen++;
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result idx=%0d", best_index);
			end else begin
				m = pending_matches.pop_front();
				if (best_index !== m.idx || best_overlap !== m.ovl || best_label !== m.lbl ||
					is_foreground !== m.fg || is_background !== m.bg) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d/%0d/%0d/%b%b got %0d/%0d/%0d/%b%b",
							m.idx, m.ovl, m.lbl, m.fg, m.bg, best_index, best_overlap,
							best_label, is_foreground, is_background);
				end
			end
		end
		out_ready <= !hold_off && ($urandom_range(0, 7) < ((matches_seen / 16) % 2 ? 8 : 5));
	end

	// watchdog: cycles without any accepted word or result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
			hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; op = 0; entry_index = 0;
		box_x1 = 0; box_y1 = 0; box_x2 = 0; box_y2 = 0; class_label = 0;
		n_gt = 0; fg_thr = FG_THR_RST; bg_hi = BG_HIGH_RST; bg_lo = BG_LOW_RST;
		words_sent = 0;
		hold_off = 0; burst_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		burst_mode = 1;
		test_random();
		test_backpressure();
		wait_idle();
		$display("Covered %0d words and %0d match results over loads, empty and full tables,",
			words_sent, matches_seen);
		$display("degenerate boxes, threshold extremes and a long output stall.");
		if (mismatches == 0 && pending_matches.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/bigm_pkg.sv
hdl/bigm_dp.sv
hdl/bigm_ctrl.sv
hdl/box_iou_gt_matcher.sv
verif/testbench.sv
